// File: src/smap_pkg.sv
// Shared codes, constants and types of the STUN mapped address parser.
`timescale 1ns / 1ps

package smap_pkg;

   localparam logic [2:0] STATUS_NOT_STUN      = 3'd0;
   localparam logic [2:0] STATUS_NOT_BINDING   = 3'd1;
   localparam logic [2:0] STATUS_TXN_MISMATCH  = 3'd2;
   localparam logic [2:0] STATUS_TRUNCATED     = 3'd3;
   localparam logic [2:0] STATUS_NONE          = 3'd4;
   localparam logic [2:0] STATUS_NOT_IPV4      = 3'd5;
   localparam logic [2:0] STATUS_IPV4_FOUND    = 3'd6;

   localparam logic [1:0] PHASE_HEADER = 2'd0;
   localparam logic [1:0] PHASE_SKIP   = 2'd1;
   localparam logic [1:0] PHASE_TARGET = 2'd2;
   localparam logic [1:0] PHASE_STOP   = 2'd3;

   localparam logic [1:0] CSR_TXN_HIGH  = 2'd0;
   localparam logic [1:0] CSR_TXN_LOW   = 2'd1;
   localparam logic [1:0] CSR_TXN_ARMED = 2'd2;

   localparam logic [15:0] BINDING_SUCCESS  = 16'h0101;
   localparam logic [15:0] ATTR_XOR_MAPPED  = 16'h0020;
   localparam logic [7:0]  FAMILY_IPV4      = 8'h01;
   localparam logic [7:0]  FIRST_BYTE_MASK  = 8'hC0;
   localparam logic [31:0] MAGIC_COOKIE     = 32'h2112A442;
   localparam int          HeaderBytes      = 20;
   localparam int          AttrHeaderBytes  = 4;
   localparam int          MinMappedLength  = 8;

   // Attribute walker state as seen after the current byte.
   typedef struct packed {
      logic [1:0]  phase;
      logic        value_short;
      logic [7:0]  family;
      logic [15:0] port;
      logic [31:0] address;
   } walk_type;

endpackage

// File: src/smap_walk.sv
// Attribute walker: follows attribute headers and captures XOR-MAPPED-ADDRESS.
`timescale 1ns / 1ps

module smap_walk #(
   parameter int POSITION_BITS = 17
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     take,
   input  logic                     clear,
   input  logic [POSITION_BITS-1:0] position,
   input  logic [POSITION_BITS-1:0] count,
   input  logic [POSITION_BITS-1:0] declared_end,
   input  logic [7:0]               data_byte,
   output smap_pkg::walk_type       walk
);

   localparam int W = POSITION_BITS + 2;

   logic [1:0]   phase_ff, phase_in;
   logic [W-1:0] offset_ff, offset_in;
   logic [1:0]   hdr_cnt_ff, hdr_cnt_in;
   logic [3:0]   val_cnt_ff, val_cnt_in;
   logic [15:0]  code_ff, code_in;
   logic [15:0]  length_ff, length_in;
   logic [W-1:0] value_end_ff, value_end_in;
   logic [W-1:0] skip_next_ff, skip_next_in;
   logic [7:0]   family_ff, family_in;
   logic [15:0]  port_ff, port_in;
   logic [31:0]  address_ff, address_in;

   logic [1:0]   phase_mid;
   logic [W-1:0] base;
   logic [W-1:0] base_plus4;
   logic [1:0]   hcnt;
   logic [15:0]  length_new;
   logic [16:0]  length_pad;
   logic [W-1:0] pos_w;
   logic         active;

   always_comb begin
      phase_in     = phase_ff;
      offset_in    = offset_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      val_cnt_in   = val_cnt_ff;
      code_in      = code_ff;
      length_in    = length_ff;
      value_end_in = value_end_ff;
      skip_next_in = skip_next_ff;
      family_in    = family_ff;
      port_in      = port_ff;
      address_in   = address_ff;

      pos_w      = W'(position);
      active     = take && (position >= POSITION_BITS'(smap_pkg::HeaderBytes));
      phase_mid  = phase_ff;
      base       = offset_ff;
      hcnt       = hdr_cnt_ff;
      length_new = {length_ff[7:0], data_byte};
      length_pad = ({1'b0, length_new} + 17'd3) & 17'h1FFFC;

      // Leave the skipped attribute on the first byte of the next header.
      if (active && phase_ff == smap_pkg::PHASE_SKIP && pos_w == skip_next_ff) begin
         phase_mid = smap_pkg::PHASE_HEADER;
         phase_in  = smap_pkg::PHASE_HEADER;
         offset_in = skip_next_ff;
         base      = skip_next_ff;
         hcnt      = 2'd0;
      end
      base_plus4 = base + W'(smap_pkg::AttrHeaderBytes);

      if (active && phase_mid == smap_pkg::PHASE_HEADER) begin
         if (hcnt == 2'd0 && base_plus4 > W'(declared_end)) begin
            phase_in = smap_pkg::PHASE_STOP;
         end else begin
            hdr_cnt_in = hcnt + 2'd1;
            case (hcnt)
               2'd0, 2'd1: code_in = {code_ff[7:0], data_byte};
               2'd2:       length_in = length_new;
               2'd3: begin
                  length_in    = length_new;
                  value_end_in = base_plus4 + W'(length_new);
                  skip_next_in = base_plus4 + W'(length_pad);
                  val_cnt_in   = 4'd0;
                  if (code_ff == smap_pkg::ATTR_XOR_MAPPED &&
                      length_new >= 16'(smap_pkg::MinMappedLength)) begin
                     phase_in = smap_pkg::PHASE_TARGET;
                  end else begin
                     phase_in = smap_pkg::PHASE_SKIP;
                  end
               end
               default: ;
            endcase
         end
      end else if (active && phase_mid == smap_pkg::PHASE_TARGET) begin
         if (val_cnt_ff != 4'd8) begin
            val_cnt_in = val_cnt_ff + 4'd1;
         end
         case (val_cnt_ff) inside
            4'd1:         family_in  = data_byte;
            [4'd2:4'd3]:  port_in    = {port_ff[7:0], data_byte};
            [4'd4:4'd7]:  address_in = {address_ff[23:0], data_byte};
            default: ;
         endcase
      end

      walk.phase       = phase_in;
      walk.value_short = W'(count) < value_end_in;
      walk.family      = family_in;
      walk.port        = port_in;
      walk.address     = address_in;

      // Reset the walk phase, header offset and header byte count at the end of the datagram.
      if (clear) begin
         phase_in   = smap_pkg::PHASE_HEADER;
         offset_in  = W'(smap_pkg::HeaderBytes);
         hdr_cnt_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= smap_pkg::PHASE_HEADER;
         offset_ff  <= W'(smap_pkg::HeaderBytes);
         hdr_cnt_ff <= 2'd0;
         val_cnt_ff <= 4'd0;
      end else begin
         phase_ff   <= phase_in;
         offset_ff  <= offset_in;
         hdr_cnt_ff <= hdr_cnt_in;
         val_cnt_ff <= val_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      length_ff    <= length_in;
      value_end_ff <= value_end_in;
      skip_next_ff <= skip_next_in;
      family_ff    <= family_in;
      port_ff      <= port_in;
      address_ff   <= address_in;
   end

endmodule

// File: src/stun_mapped_address_parser.sv
// Top level of the STUN XOR-MAPPED-ADDRESS parser.
`timescale 1ns / 1ps

// Usage:
//   The req channel carries one datagram byte per item, req_last_byte marking
//   the final byte. Every byte updates the header checks and the attribute
//   walker in the cycle it is accepted; nothing is returned for inner bytes.
//   On the final byte one status item is placed in the rsp output register:
//   rsp_status, rsp_mapped_address (status 6) and rsp_mapped_port (5 or 6).
//   The registered status item appears in the cycle after the final byte.
//   Throughput: one byte per cycle while req_stall is low, set by the single
//   registered update path. A waiting status item blocks new bytes only while
//   rsp_stall is high; req_stall rises only while the output register is full
//   and rsp_stall is high, so the item held there stays stable until taken.
//   The csr port writes the expected transaction id (index 0 bytes 8..15,
//   index 1 bytes 16..19) and the armed flag (index 2); write only while idle.
//   Reset clears the control registers, empties the output register and restarts
//   the datagram at byte zero. Bytes from 2^POSITION_BITS - 1 on are ignored.
module stun_mapped_address_parser #(
   parameter int POSITION_BITS = 17
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_mapped_address,
   output logic [15:0] rsp_mapped_port,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   localparam int P = POSITION_BITS;
   localparam logic [P-1:0] PosMax = '1;

   // Configuration registers.
   logic [63:0] txn_high_ff;
   logic [31:0] txn_low_ff;
   logic        txn_armed_ff;

   // Per-datagram header state.
   logic [P-1:0] position_ff, position_in;
   logic [P-1:0] declared_end_ff, declared_end_in;
   logic [15:0]  msg_type_ff, msg_type_in;
   logic         first_flag_ff, first_flag_in;
   logic         txn_equal_ff, txn_equal_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   logic [2:0]   status_ff, status_in;
   logic [31:0]  address_ff, address_in;
   logic [15:0]  port_ff, port_in;

   logic         accept;
   logic         take;
   logic         finish;
   logic [P:0]   end_sum;
   logic [95:0]  txn_id;
   logic [3:0]   id_sel;
   logic [7:0]   id_want;
   smap_pkg::walk_type walk;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign take      = accept && (position_ff != PosMax);
   assign finish    = accept && req_last_byte;

   assign txn_id  = {txn_high_ff, txn_low_ff};
   assign id_sel  = 4'(5'd19 - position_ff[4:0]);
   assign id_want = txn_id[{id_sel, 3'b000} +: 8];
   assign end_sum = ({1'b0, declared_end_ff} | (P+1)'(req_data_byte))
                    + (P+1)'(smap_pkg::HeaderBytes);

   smap_walk #(
      .POSITION_BITS(P)
   ) u_walk (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .clear        (finish),
      .position     (position_ff),
      .count        (position_in),
      .declared_end (declared_end_ff),
      .data_byte    (req_data_byte),
      .walk         (walk)
   );

   // Header checks: first byte, message type, length, transaction id.
   always_comb begin
      position_in     = position_ff;
      declared_end_in = declared_end_ff;
      msg_type_in     = msg_type_ff;
      first_flag_in   = first_flag_ff;
      txn_equal_in    = txn_equal_ff;

      if (take) begin
         position_in = position_ff + P'(1);
         if (position_ff == P'(0) && (req_data_byte & smap_pkg::FIRST_BYTE_MASK) != 8'd0) begin
            first_flag_in = 1'b1;
         end
         if (position_ff < P'(2)) begin
            msg_type_in = {msg_type_ff[7:0], req_data_byte};
         end
         if (position_ff == P'(2)) begin
            declared_end_in = P'({req_data_byte, 8'h00});
         end
         if (position_ff == P'(3)) begin
            declared_end_in = (end_sum > (P+1)'(PosMax)) ? PosMax : end_sum[P-1:0];
         end
         if (position_ff >= P'(8) && position_ff < P'(smap_pkg::HeaderBytes)) begin
            if (id_want != req_data_byte || !txn_armed_ff) begin
               txn_equal_in = 1'b0;
            end
         end
      end
   end

   // Final status from the state as it stands after the last byte.
   always_comb begin
      address_in = 32'd0;
      port_in    = 16'd0;
      if (position_in < P'(smap_pkg::HeaderBytes) || first_flag_in) begin
         status_in = smap_pkg::STATUS_NOT_STUN;
      end else if (msg_type_in != smap_pkg::BINDING_SUCCESS) begin
         status_in = smap_pkg::STATUS_NOT_BINDING;
      end else if (!txn_equal_in) begin
         status_in = smap_pkg::STATUS_TXN_MISMATCH;
      end else if (walk.phase == smap_pkg::PHASE_SKIP) begin
         status_in = walk.value_short ? smap_pkg::STATUS_TRUNCATED : smap_pkg::STATUS_NONE;
      end else if (walk.phase == smap_pkg::PHASE_TARGET) begin
         if (walk.value_short) begin
            status_in = smap_pkg::STATUS_TRUNCATED;
         end else begin
            port_in = walk.port ^ smap_pkg::MAGIC_COOKIE[31:16];
            if (walk.family == smap_pkg::FAMILY_IPV4) begin
               status_in  = smap_pkg::STATUS_IPV4_FOUND;
               address_in = walk.address ^ smap_pkg::MAGIC_COOKIE;
            end else begin
               status_in = smap_pkg::STATUS_NOT_IPV4;
            end
         end
      end else begin
         status_in = smap_pkg::STATUS_NONE;
      end
   end

   // Hold a status item until taken; load a new one on the final byte.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         txn_high_ff     <= 64'd0;
         txn_low_ff      <= 32'd0;
         txn_armed_ff    <= 1'b0;
         position_ff     <= '0;
         declared_end_ff <= '0;
         msg_type_ff     <= 16'd0;
         first_flag_ff   <= 1'b0;
         txn_equal_ff    <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               smap_pkg::CSR_TXN_HIGH:  txn_high_ff  <= csr_write_data;
               smap_pkg::CSR_TXN_LOW:   txn_low_ff   <= csr_write_data[31:0];
               smap_pkg::CSR_TXN_ARMED: txn_armed_ff <= csr_write_data[0];
               default: ;
            endcase
         end
         rsp_valid_ff <= rsp_valid_in;
         if (finish) begin
            position_ff     <= '0;
            declared_end_ff <= '0;
            msg_type_ff     <= 16'd0;
            first_flag_ff   <= 1'b0;
            txn_equal_ff    <= 1'b1;
         end else begin
            position_ff     <= position_in;
            declared_end_ff <= declared_end_in;
            msg_type_ff     <= msg_type_in;
            first_flag_ff   <= first_flag_in;
            txn_equal_ff    <= txn_equal_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff  <= status_in;
         address_ff <= address_in;
         port_ff    <= port_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_mapped_address = address_ff;
   assign rsp_mapped_port    = port_ff;

endmodule
